FILE: hdl/maxwell_2d_upwind_flux_stencil_macros.svh
// Assertion macros used by the checker file of the Maxwell flux stencil.
// Depends on nothing; take it in by include with the bare file name.
`ifndef MAXWELL_2D_UPWIND_FLUX_STENCIL_MACROS_SVH
`define MAXWELL_2D_UPWIND_FLUX_STENCIL_MACROS_SVH

// Property checked on every rising edge outside reset.
`define M2D_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge, reset included.
`define M2D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/m2duf_pkg.sv
// Constants shared by the Maxwell flux stencil and its interfaces.
// Depends on nothing.
package m2duf_pkg;

  // Field slots within one packed cell: Ex Ey Ez Bx By Bz.
  localparam int S_EX = 0;
  localparam int S_EY = 1;
  localparam int S_EZ = 2;
  localparam int S_BX = 3;
  localparam int S_BY = 4;
  localparam int S_BZ = 5;
  localparam int N_FIELD = 6;

  // Configuration register indexes.
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_LINE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_ROW_COUNT   = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_INV_SIZE    = 2'd2;
  localparam int CFG_DATA_BITS = 32;

  // Geometry register widths and limits.
  localparam int GEOM_BITS = 11;
  localparam int MAX_ROWS  = 1024;
  localparam int ROW_BITS  = 10;
  localparam int INV_BITS  = 31;

  localparam logic [GEOM_BITS-1:0] LEN_RESET  = 11'd66;
  localparam logic [GEOM_BITS-1:0] ROWS_RESET = 11'd66;
  localparam logic [INV_BITS-1:0]  INV_RESET  = 31'd655360;

  // Scaling: the flux sum carries 8x scale on Q.16, so a shift of 19 returns Q.16.
  localparam int FRAC_SHIFT = 19;

endpackage

FILE: hdl/m2duf_if.sv
// Channel interfaces of the Maxwell flux stencil: cells in, rates out, configuration.
// Depends on m2duf_pkg.
interface m2duf_cell_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] e_x;
  logic signed [WORD_BITS-1:0] e_y;
  logic signed [WORD_BITS-1:0] e_z;
  logic signed [WORD_BITS-1:0] b_x;
  logic signed [WORD_BITS-1:0] b_y;
  logic signed [WORD_BITS-1:0] b_z;
  modport source (output valid, e_x, e_y, e_z, b_x, b_y, b_z, input ready);
  modport sink   (input valid, e_x, e_y, e_z, b_x, b_y, b_z, output ready);
endinterface

interface m2duf_rate_if #(parameter int WORD_BITS = 32);
  logic                        valid;
  logic                        ready;
  logic signed [WORD_BITS-1:0] rate_b_x;
  logic signed [WORD_BITS-1:0] rate_b_y;
  logic signed [WORD_BITS-1:0] rate_b_z;
  logic signed [WORD_BITS-1:0] rate_e_x;
  logic signed [WORD_BITS-1:0] rate_e_y;
  logic signed [WORD_BITS-1:0] rate_e_z;
  logic                        last_of_frame;
  modport source (output valid, rate_b_x, rate_b_y, rate_b_z, rate_e_x, rate_e_y,
                  rate_e_z, last_of_frame, input ready);
  modport sink   (input valid, rate_b_x, rate_b_y, rate_b_z, rate_e_x, rate_e_y,
                  rate_e_z, last_of_frame, output ready);
endinterface

interface m2duf_cfg_if;
  logic                                    valid;
  logic                                    ready;
  logic [m2duf_pkg::CFG_IDX_BITS-1:0]      index;
  logic [m2duf_pkg::CFG_DATA_BITS-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/maxwell_2d_upwind_flux_stencil.sv
// Streaming 2D Maxwell upwind flux stencil: line memory, 3x3 window, flux pipeline.
// Depends on m2duf_pkg and the channel interfaces in m2duf_if.sv.
//
//   channel | dir | transfer carries
//   --------+-----+-------------------------------------------------
//   cfg     | in  | register index and data (always ready)
//   cells   | in  | one grid cell, Ex Ey Ez Bx By Bz
//   rates   | out | six time derivatives and last_of_frame
//
// One cell is taken per cycle unless the pipeline stalls; the line memory is read at the transfer and
// written back in the next cycle, so a column is never re-read before its write.
// A result passes the line-memory read, window, corner, sign and product stages into the output register.
// Reset clears counters, configuration registers and pipeline valids; memory contents stay undefined.
// The pipeline stalls only while its last stage and the output register both hold
// results that the sink does not take.
module maxwell_2d_upwind_flux_stencil #(
  parameter int MAX_LINE    = 1024,
  parameter int WORD_BITS   = 32,
  parameter int GHOST_CELLS = 1
) (
  input  logic             clk,
  input  logic             rst,
  m2duf_cfg_if.sink        cfg,
  m2duf_cell_if.sink       cells,
  m2duf_rate_if.source     rates
);
  import m2duf_pkg::*;

  localparam int W    = WORD_BITS;
  localparam int CB   = N_FIELD * W;
  localparam int AW   = $clog2(MAX_LINE);
  localparam int EW   = ((AW > GEOM_BITS) ? AW : GEOM_BITS) + 2;
  localparam int DW   = W + 8;
  localparam int HW   = DW - FRAC_SHIFT;
  localparam int HPW  = HW + INV_BITS;
  localparam int LPW  = FRAC_SHIFT + INV_BITS;
  localparam int QW   = HPW + 1;

  typedef logic signed [DW-1:0] wide_t;

  // Field of a packed cell, sign-extended to the working width.
  function automatic wide_t fld(input logic [CB-1:0] c, input int s);
    fld = DW'($signed(c[s*W +: W]));
  endfunction

  // Upwind corner Ez at 4x scale.
  function automatic wide_t corner_e(input logic [CB-1:0] sw, input logic [CB-1:0] se,
                                     input logic [CB-1:0] nw, input logic [CB-1:0] ne);
    corner_e = fld(sw, S_EZ) + fld(se, S_EZ) + fld(nw, S_EZ) + fld(ne, S_EZ)
             + fld(nw, S_BX) + fld(ne, S_BX) - fld(sw, S_BX) - fld(se, S_BX)
             + fld(sw, S_BY) + fld(nw, S_BY) - fld(se, S_BY) - fld(ne, S_BY);
  endfunction

  // Upwind corner Bz at 4x scale.
  function automatic wide_t corner_b(input logic [CB-1:0] sw, input logic [CB-1:0] se,
                                     input logic [CB-1:0] nw, input logic [CB-1:0] ne);
    corner_b = fld(sw, S_BZ) + fld(se, S_BZ) + fld(nw, S_BZ) + fld(ne, S_BZ)
             + fld(nw, S_EX) + fld(ne, S_EX) - fld(sw, S_EX) - fld(se, S_EX)
             + fld(sw, S_EY) + fld(nw, S_EY) - fld(se, S_EY) - fld(ne, S_EY);
  endfunction

  // Configuration registers.
  logic [GEOM_BITS-1:0] line_length;
  logic [GEOM_BITS-1:0] row_count;
  logic [INV_BITS-1:0]  inv_size;
  logic                 cfg_wr;

  assign cfg.ready = 1'b1;
  assign cfg_wr    = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= LEN_RESET;
      row_count   <= ROWS_RESET;
      inv_size    <= INV_RESET;
    end else if (cfg_wr) begin
      unique case (cfg.index)
        REG_LINE_LENGTH: line_length <= cfg.data[GEOM_BITS-1:0];
        REG_ROW_COUNT:   row_count   <= cfg.data[GEOM_BITS-1:0];
        REG_INV_SIZE:    inv_size    <= cfg.data[INV_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Effective geometry, clamped to the supported range.
  logic [EW-1:0] len_eff;
  logic [EW-1:0] rows_eff;

  always_comb begin
    len_eff = EW'(line_length);
    if (len_eff < EW'(3)) len_eff = EW'(3);
    if (len_eff > EW'(MAX_LINE)) len_eff = EW'(MAX_LINE);
    rows_eff = EW'(row_count);
    if (rows_eff < EW'(3)) rows_eff = EW'(3);
    if (rows_eff > EW'(MAX_ROWS)) rows_eff = EW'(MAX_ROWS);
  end

  // Pipeline control: stall only when a finished result cannot move on.
  logic en;
  logic acc;
  logic p5_v;

  assign en          = !(p5_v && rates.valid && !rates.ready);
  assign cells.ready = en;
  assign acc         = cells.valid && en;

  // Raster position of the incoming cell.
  logic [AW-1:0]       col;
  logic [ROW_BITS-1:0] row;
  logic [EW-1:0]       c_cur, r_cur, c_inc, r_inc;
  logic                emit, last;

  always_comb begin
    c_cur = EW'(col);
    r_cur = EW'(row);
    if (c_cur >= len_eff || r_cur >= rows_eff) begin
      c_cur = '0;
      r_cur = '0;
    end
    emit = (r_cur >= EW'(GHOST_CELLS + 1)) && (r_cur + EW'(GHOST_CELLS) <= rows_eff)
        && (c_cur >= EW'(GHOST_CELLS + 1)) && (c_cur + EW'(GHOST_CELLS) <= len_eff);
    last = (r_cur + EW'(GHOST_CELLS) == rows_eff) && (c_cur + EW'(GHOST_CELLS) == len_eff);
    c_inc = c_cur + EW'(1);
    r_inc = r_cur;
    if (c_inc >= len_eff) begin
      c_inc = '0;
      r_inc = r_cur + EW'(1);
      if (r_inc >= rows_eff) r_inc = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (cfg_wr && (cfg.index == REG_LINE_LENGTH || cfg.index == REG_ROW_COUNT)) begin
      col <= '0;
      row <= '0;
    end else if (acc) begin
      col <= c_inc[AW-1:0];
      row <= r_inc[ROW_BITS-1:0];
    end
  end

  // Line memory: each entry holds the previous row (low half) and the row before it.
  logic [2*CB-1:0] line_mem [MAX_LINE];
  logic [2*CB-1:0] rd;
  logic [CB-1:0]   cur;
  logic [CB-1:0]   p1_cur;
  logic [AW-1:0]   wr_addr;
  logic            wr_pend;
  logic            p1_v, p1_emit, p1_last;

  assign cur = {cells.b_z, cells.b_y, cells.b_x, cells.e_z, cells.e_y, cells.e_x};

  always_ff @(posedge clk) begin
    if (acc) begin
      rd      <= line_mem[c_cur[AW-1:0]];
      p1_cur  <= cur;
      p1_emit <= emit;
      p1_last <= last;
      wr_addr <= c_cur[AW-1:0];
    end
    if (wr_pend) begin
      line_mem[wr_addr] <= {rd[CB-1:0], p1_cur};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_pend <= 1'b0;
      p1_v    <= 1'b0;
    end else begin
      wr_pend <= acc;
      if (en) p1_v <= acc;
    end
  end

  // 3x3 window, shifted one column per cell.
  logic [CB-1:0] win [3][3];
  logic          p2_v, p2_last;

  always_ff @(posedge clk) begin
    if (en && p1_v) begin
      for (int a = 0; a < 3; a++) begin
        win[a][0] <= win[a][1];
        win[a][1] <= win[a][2];
      end
      win[0][2] <= rd[2*CB-1:CB];
      win[1][2] <= rd[CB-1:0];
      win[2][2] <= p1_cur;
    end
    if (en) p2_last <= p1_last;
  end

  // Corners and the z-component flux sums.
  wide_t e11, e12, e21, e22, b11, b12, b21, b22, d_bz3, d_ez3;
  logic  p3_v, p3_last;

  always_ff @(posedge clk) begin
    if (en) begin
      e11 <= corner_e(win[0][0], win[1][0], win[0][1], win[1][1]);
      e12 <= corner_e(win[0][1], win[1][1], win[0][2], win[1][2]);
      e21 <= corner_e(win[1][0], win[2][0], win[1][1], win[2][1]);
      e22 <= corner_e(win[1][1], win[2][1], win[1][2], win[2][2]);
      b11 <= corner_b(win[0][0], win[1][0], win[0][1], win[1][1]);
      b12 <= corner_b(win[0][1], win[1][1], win[0][2], win[1][2]);
      b21 <= corner_b(win[1][0], win[2][0], win[1][1], win[2][1]);
      b22 <= corner_b(win[1][1], win[2][1], win[1][2], win[2][2]);
      d_bz3 <= 4 * (fld(win[2][1], S_EY) - fld(win[0][1], S_EY))
             - 4 * (fld(win[2][1], S_BZ) - 2 * fld(win[1][1], S_BZ) + fld(win[0][1], S_BZ))
             - 4 * (fld(win[1][2], S_EX) - fld(win[1][0], S_EX))
             - 4 * (fld(win[1][2], S_BZ) - 2 * fld(win[1][1], S_BZ) + fld(win[1][0], S_BZ));
      d_ez3 <= -4 * (fld(win[2][1], S_BY) - fld(win[0][1], S_BY))
             - 4 * (fld(win[2][1], S_EZ) - 2 * fld(win[1][1], S_EZ) + fld(win[0][1], S_EZ))
             + 4 * (fld(win[1][2], S_BX) - fld(win[1][0], S_BX))
             - 4 * (fld(win[1][2], S_EZ) - 2 * fld(win[1][1], S_EZ) + fld(win[1][0], S_EZ));
      p3_last <= p2_last;
    end
  end

  // Flux differences as magnitude and sign; output order Bx By Bz Ex Ey Ez.
  wide_t         d_sum [N_FIELD];
  logic [DW-1:0] mag4  [N_FIELD];
  logic          neg4  [N_FIELD];
  logic          p4_v, p4_last;

  always_comb begin
    d_sum[0] = e12 + e22 - e11 - e21;
    d_sum[1] = e11 + e12 - e21 - e22;
    d_sum[2] = d_bz3;
    d_sum[3] = b11 + b21 - b12 - b22;
    d_sum[4] = b21 + b22 - b11 - b12;
    d_sum[5] = d_ez3;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_FIELD; i++) begin
        mag4[i] <= d_sum[i][DW-1] ? DW'(-d_sum[i]) : DW'(d_sum[i]);
        neg4[i] <= (d_sum[i] > 0);
      end
      p4_last <= p3_last;
    end
  end

  // Split product by the inverse cell size: high part and the 19 fraction bits.
  logic [HPW-1:0] hi5  [N_FIELD];
  logic [LPW-1:0] lo5  [N_FIELD];
  logic           neg5 [N_FIELD];
  logic           p5_last;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < N_FIELD; i++) begin
        hi5[i]  <= HPW'(mag4[i][DW-1:FRAC_SHIFT]) * HPW'(inv_size);
        lo5[i]  <= LPW'(mag4[i][FRAC_SHIFT-1:0]) * LPW'(inv_size);
        neg5[i] <= neg4[i];
      end
      p5_last <= p4_last;
    end
  end

  // Pipeline valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      p2_v <= 1'b0;
      p3_v <= 1'b0;
      p4_v <= 1'b0;
      p5_v <= 1'b0;
    end else if (en) begin
      p2_v <= p1_v && p1_emit;
      p3_v <= p2_v;
      p4_v <= p3_v;
      p5_v <= p4_v;
    end
  end

  // Rounding, negation and saturation into the output register.
  logic [QW-1:0]  q    [N_FIELD];
  logic [W-1:0]   sat  [N_FIELD];
  logic [LPW:0]   lo_r [N_FIELD];

  always_comb begin
    for (int i = 0; i < N_FIELD; i++) begin
      lo_r[i] = (LPW + 1)'(lo5[i]) + ((LPW + 1)'(1) << (FRAC_SHIFT - 1));
      q[i]    = QW'(hi5[i]) + QW'(lo_r[i] >> FRAC_SHIFT);
      if (neg5[i]) begin
        if (q[i] >= (QW'(1) << (W - 1))) sat[i] = {1'b1, {(W-1){1'b0}}};
        else                             sat[i] = W'(-q[i]);
      end else begin
        if (q[i] >= (QW'(1) << (W - 1))) sat[i] = {1'b0, {(W-1){1'b1}}};
        else                             sat[i] = q[i][W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rates.valid <= 1'b0;
    end else if (en && p5_v) begin
      rates.valid <= 1'b1;
    end else if (rates.ready) begin
      rates.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && p5_v) begin
      rates.rate_b_x      <= sat[0];
      rates.rate_b_y      <= sat[1];
      rates.rate_b_z      <= sat[2];
      rates.rate_e_x      <= sat[3];
      rates.rate_e_y      <= sat[4];
      rates.rate_e_z      <= sat[5];
      rates.last_of_frame <= p5_last;
    end
  end

endmodule

FILE: hdl/m2duf_checker.sv
// Port-level checks of the Maxwell flux stencil, bound onto the top level.
// Depends on the assertion macros header.
`include "maxwell_2d_upwind_flux_stencil_macros.svh"

module m2duf_port_props #(
  parameter int WORD_BITS = 32
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 cfg_ready,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [WORD_BITS-1:0] out_b_x,
  input logic                 out_last
);

  // A result offered but not taken stays offered.
  `M2D_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid, "result dropped")

  // A stalled result keeps its Bx rate and last_of_frame flag.
  `M2D_ASSERT(a_out_stable, clk, rst, out_valid && !out_ready |=> $stable(out_b_x) && $stable(out_last), "payload changed while stalled")

  // No result appears in the cycle after reset.
  `M2D_ASSERT_ALWAYS(a_rst_quiet, clk, rst |=> !out_valid, "result right after reset")

  // The configuration port is never back-pressured.
  `M2D_ASSERT(a_cfg_ready, clk, rst, cfg_ready, "configuration port not ready")

endmodule

bind maxwell_2d_upwind_flux_stencil m2duf_port_props #(.WORD_BITS(WORD_BITS)) u_m2duf_checker (
  .clk       (clk),
  .rst       (rst),
  .cfg_ready (cfg.ready),
  .out_valid (rates.valid),
  .out_ready (rates.ready),
  .out_b_x   (rates.rate_b_x),
  .out_last  (rates.last_of_frame)
);
